FILE: sv/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared constants and types for the rc4 stream cipher unit: permutation
// size, default key store depth, op codes and the bundles between modules.
// ----------------------------------------------------------------------------
package rc4_pkg;

	// permutation table geometry
	localparam int PERM_SIZE = 256;
	localparam int PERM_AW   = 8;
	localparam int BYTE_W    = 8;

	// default depth of the key store
	localparam int MAX_KEY_LEN_DEF = 256;

	// operation codes carried by the operation field
	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_TEXT = 1'b1;

	// one port set of the permutation memory
	typedef struct packed {
		logic               we;
		logic [PERM_AW-1:0] waddr;
		logic [BYTE_W-1:0]  wdata;
		logic               re;
		logic [PERM_AW-1:0] raddr;
	} perm_port_t;

	// result beat from the sequencer to the output register
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] text_out;
		logic [BYTE_W-1:0] keystream;
		logic              not_ready;
	} result_t;

	// sequencer status seen by the top level
	typedef struct packed {
		logic idle;
		logic key_ready;
	} status_t;

endpackage

FILE: sv/rc4_stream_cipher_unit.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher_unit
// RC4 cipher engine: key load, key schedule and keystream generation.
//
// Input channel (in_valid/in_ready): operation, value, last. A key beat
// (operation 0) stores one key byte; bytes past MAX_KEY_LEN are dropped. A
// key beat with last set runs the key schedule: it fills the permutation
// memory, then swaps one entry pair at a time (KS_RD, KS_ADD, KS_WR_N,
// KS_WR_A), during all of which in_ready is low. Key beats give no result.
// A text beat (operation 1) gives one output beat: text_out, keystream,
// not_ready. With a scheduled key no new beat is taken until the byte is
// done, as the three dependent reads and two swap writes share the one
// permutation memory port pair; the byte passes states TX_J, TX_SW and
// TX_OUT into the output register. Before any key, the answer is zeros
// with not_ready set, in the cycle after accept. A new key being loaded
// leaves the old schedule in force until its last byte arrives.
// The output register holds a beat until out_ready; while it is full and
// not being taken, in_ready stays low and no key or text beat is accepted.
// Reset clears the indices and the key-ready flag; the memories are not
// cleared.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_unit #(
	parameter int MAX_KEY_LEN = rc4_pkg::MAX_KEY_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [rc4_pkg::BYTE_W-1:0]    value,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rc4_pkg::BYTE_W-1:0]    text_out,
	output logic [rc4_pkg::BYTE_W-1:0]    keystream,
	output logic                          not_ready
);

	localparam int KAW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;

	rc4_pkg::perm_port_t               perm_port;
	logic [rc4_pkg::BYTE_W-1:0]        perm_rdata;
	logic                              key_we;
	logic [KAW-1:0]                    key_waddr;
	logic [rc4_pkg::BYTE_W-1:0]        key_wdata;
	logic                              key_re;
	logic [KAW-1:0]                    key_raddr;
	logic [rc4_pkg::BYTE_W-1:0]        key_rdata;
	rc4_pkg::result_t                  res;
	rc4_pkg::status_t                  status;
	logic                              out_valid_q;
	logic [rc4_pkg::BYTE_W-1:0]        text_out_q;
	logic [rc4_pkg::BYTE_W-1:0]        keystream_q;
	logic                              not_ready_q;
	logic                              out_free;
	logic                              accept;

	// input handshake
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = status.idle && out_free;
	assign accept   = in_valid && in_ready;

	// permutation memory
	rc4_ram #(
		.WIDTH (rc4_pkg::BYTE_W),
		.DEPTH (rc4_pkg::PERM_SIZE)
	) u_perm_ram (
		.clk   (clk),
		.we    (perm_port.we),
		.waddr (perm_port.waddr),
		.wdata (perm_port.wdata),
		.re    (perm_port.re),
		.raddr (perm_port.raddr),
		.rdata (perm_rdata)
	);

	// key store
	rc4_ram #(
		.WIDTH (rc4_pkg::BYTE_W),
		.DEPTH (MAX_KEY_LEN)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.re    (key_re),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	// sequencer with the shared adder
	rc4_seq #(
		.MAX_KEY_LEN (MAX_KEY_LEN)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.operation  (operation),
		.value      (value),
		.last       (last),
		.perm_port  (perm_port),
		.perm_rdata (perm_rdata),
		.key_we     (key_we),
		.key_waddr  (key_waddr),
		.key_wdata  (key_wdata),
		.key_re     (key_re),
		.key_raddr  (key_raddr),
		.key_rdata  (key_rdata),
		.res        (res),
		.status     (status)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			text_out_q  <= '0;
			keystream_q <= '0;
			not_ready_q <= 1'b0;
		end else begin
			if (res.valid) begin
				out_valid_q <= 1'b1;
				text_out_q  <= res.text_out;
				keystream_q <= res.keystream;
				not_ready_q <= res.not_ready;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign text_out  = text_out_q;
	assign keystream = keystream_q;
	assign not_ready = not_ready_q;

	// a result beat never lands on a full output register that is not being taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> out_free)
		else $error("result beat while output register is full");

	// a key beat produces no cipher result in the following cycle
	a_key_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == rc4_pkg::OP_KEY) |=> (!res.valid || res.not_ready))
		else $error("key beat produced a result");

	// text before any key is answered by the output register with zeros and not_ready
	a_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == rc4_pkg::OP_TEXT && !status.key_ready)
		|=> (out_valid && not_ready && text_out == '0 && keystream == '0))
		else $error("missing not-ready answer");

endmodule

FILE: sv/rc4_ram.sv
// ----------------------------------------------------------------------------
// rc4_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. A read at the address being written returns old data.
// ----------------------------------------------------------------------------
module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/rc4_seq.sv
// ----------------------------------------------------------------------------
// rc4_seq
// Sequencer for the cipher: loads key bytes, runs the key schedule one swap
// at a time and steps the keystream generator, with a single shared 8-bit
// adder for the j, schedule accumulator and output index sums.
// ----------------------------------------------------------------------------
module rc4_seq #(
	parameter int MAX_KEY_LEN = rc4_pkg::MAX_KEY_LEN_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// accepted input beat
	input  logic                                  accept,
	input  logic                                  operation,
	input  logic [rc4_pkg::BYTE_W-1:0]            value,
	input  logic                                  last,
	// permutation memory
	output rc4_pkg::perm_port_t                   perm_port,
	input  logic [rc4_pkg::BYTE_W-1:0]            perm_rdata,
	// key store
	output logic                                  key_we,
	output logic [((MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1)-1:0] key_waddr,
	output logic [rc4_pkg::BYTE_W-1:0]            key_wdata,
	output logic                                  key_re,
	output logic [((MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1)-1:0] key_raddr,
	input  logic [rc4_pkg::BYTE_W-1:0]            key_rdata,
	// result and status
	output rc4_pkg::result_t                      res,
	output rc4_pkg::status_t                      status
);

	localparam int KCW = $clog2(MAX_KEY_LEN + 1);
	localparam int KAW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
	localparam logic [rc4_pkg::PERM_AW-1:0] LAST_IDX = rc4_pkg::PERM_AW'(rc4_pkg::PERM_SIZE - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_KS_RD,
		ST_KS_ADD,
		ST_KS_WR_N,
		ST_KS_WR_A,
		ST_TX_J,
		ST_TX_SW,
		ST_TX_OUT
	} state_t;

	state_t                       state_q;
	logic [KCW-1:0]               key_count_q;
	logic [KCW-1:0]               kidx_q;
	logic [KCW-1:0]               kidx_nx;
	logic [rc4_pkg::PERM_AW-1:0]  n_q;
	logic [rc4_pkg::BYTE_W-1:0]   acc_q;
	logic [rc4_pkg::BYTE_W-1:0]   sn_q;
	logic [rc4_pkg::PERM_AW-1:0]  i_q;
	logic [rc4_pkg::PERM_AW-1:0]  j_q;
	logic [rc4_pkg::BYTE_W-1:0]   si_q;
	logic [rc4_pkg::BYTE_W-1:0]   sj_q;
	logic [rc4_pkg::PERM_AW-1:0]  t_q;
	logic [rc4_pkg::BYTE_W-1:0]   text_q;
	logic                         key_ready_q;
	logic                         key_room;
	logic [rc4_pkg::BYTE_W-1:0]   add_a;
	logic [rc4_pkg::BYTE_W-1:0]   add_b;
	logic [rc4_pkg::BYTE_W-1:0]   add_c;
	logic [rc4_pkg::BYTE_W-1:0]   add_y;
	logic [rc4_pkg::BYTE_W-1:0]   ks;

	assign key_room = (key_count_q < KCW'(MAX_KEY_LEN));
	assign kidx_nx  = kidx_q + KCW'(1);

	// shared adder operand select
	always_comb begin
		add_a = '0;
		add_b = '0;
		add_c = '0;
		unique case (state_q)
			ST_KS_ADD: begin
				add_a = acc_q;
				add_b = perm_rdata;
				add_c = key_rdata;
			end
			ST_TX_J: begin
				add_a = j_q;
				add_b = perm_rdata;
			end
			ST_TX_SW: begin
				add_a = si_q;
				add_b = perm_rdata;
			end
			default: begin
				add_a = '0;
			end
		endcase
	end

	assign add_y = add_a + add_b + add_c;

	// output byte: forward the swap writes that the read of S[t] does not see
	always_comb begin
		priority if (t_q == j_q) begin
			ks = si_q;
		end else if (t_q == i_q) begin
			ks = sj_q;
		end else begin
			ks = perm_rdata;
		end
	end

	// memory port control
	always_comb begin
		perm_port = '0;
		key_we    = 1'b0;
		key_waddr = key_count_q[KAW-1:0];
		key_wdata = value;
		key_re    = 1'b0;
		key_raddr = kidx_q[KAW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (accept && operation == rc4_pkg::OP_KEY) begin
					key_we = key_room;
				end
				if (accept && operation == rc4_pkg::OP_TEXT && key_ready_q) begin
					perm_port.re    = 1'b1;
					perm_port.raddr = i_q + 8'd1;
				end
			end
			ST_INIT: begin
				perm_port.we    = 1'b1;
				perm_port.waddr = n_q;
				perm_port.wdata = n_q;
			end
			ST_KS_RD: begin
				perm_port.re    = 1'b1;
				perm_port.raddr = n_q;
				key_re          = 1'b1;
			end
			ST_KS_ADD: begin
				perm_port.re    = 1'b1;
				perm_port.raddr = add_y;
			end
			ST_KS_WR_N: begin
				perm_port.we    = 1'b1;
				perm_port.waddr = n_q;
				perm_port.wdata = perm_rdata;
			end
			ST_KS_WR_A: begin
				perm_port.we    = 1'b1;
				perm_port.waddr = acc_q;
				perm_port.wdata = sn_q;
			end
			ST_TX_J: begin
				perm_port.re    = 1'b1;
				perm_port.raddr = add_y;
			end
			ST_TX_SW: begin
				perm_port.we    = 1'b1;
				perm_port.waddr = i_q;
				perm_port.wdata = perm_rdata;
				perm_port.re    = 1'b1;
				perm_port.raddr = add_y;
			end
			ST_TX_OUT: begin
				perm_port.we    = 1'b1;
				perm_port.waddr = j_q;
				perm_port.wdata = si_q;
			end
			default: begin
				perm_port = '0;
			end
		endcase
	end

	// result beat: not-ready answer at accept, keystream byte at the end
	always_comb begin
		res = '0;
		if (state_q == ST_TX_OUT) begin
			res.valid     = 1'b1;
			res.text_out  = text_q ^ ks;
			res.keystream = ks;
		end else if (state_q == ST_IDLE && accept && operation == rc4_pkg::OP_TEXT
				&& !key_ready_q) begin
			res.valid     = 1'b1;
			res.not_ready = 1'b1;
		end
	end

	assign status.idle      = (state_q == ST_IDLE);
	assign status.key_ready = key_ready_q;

	// sequencer state and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_count_q <= '0;
			kidx_q      <= '0;
			n_q         <= '0;
			acc_q       <= '0;
			sn_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			si_q        <= '0;
			sj_q        <= '0;
			t_q         <= '0;
			text_q      <= '0;
			key_ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && operation == rc4_pkg::OP_KEY) begin
						if (key_room) begin
							key_count_q <= key_count_q + KCW'(1);
						end
						if (last) begin
							n_q     <= '0;
							state_q <= ST_INIT;
						end
					end else if (accept && key_ready_q) begin
						i_q     <= i_q + 8'd1;
						text_q  <= value;
						state_q <= ST_TX_J;
					end
				end
				ST_INIT: begin
					n_q <= n_q + 8'd1;
					if (n_q == LAST_IDX) begin
						acc_q   <= '0;
						kidx_q  <= '0;
						state_q <= ST_KS_RD;
					end
				end
				ST_KS_RD: begin
					state_q <= ST_KS_ADD;
				end
				ST_KS_ADD: begin
					sn_q    <= perm_rdata;
					acc_q   <= add_y;
					state_q <= ST_KS_WR_N;
				end
				ST_KS_WR_N: begin
					state_q <= ST_KS_WR_A;
				end
				ST_KS_WR_A: begin
					n_q    <= n_q + 8'd1;
					kidx_q <= (kidx_nx == key_count_q) ? '0 : kidx_nx;
					if (n_q == LAST_IDX) begin
						key_ready_q <= 1'b1;
						i_q         <= '0;
						j_q         <= '0;
						key_count_q <= '0;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_KS_RD;
					end
				end
				ST_TX_J: begin
					si_q    <= perm_rdata;
					j_q     <= add_y;
					state_q <= ST_TX_SW;
				end
				ST_TX_SW: begin
					sj_q    <= perm_rdata;
					t_q     <= add_y;
					state_q <= ST_TX_OUT;
				end
				ST_TX_OUT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
